// File: rtl/trilinear_splat_accumulator_unit_macros.svh
// Assertion macros for the trilinear splat accumulator.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef TRILINEAR_SPLAT_ACCUMULATOR_UNIT_MACROS_SVH
`define TRILINEAR_SPLAT_ACCUMULATOR_UNIT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define TSA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define TSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tsa_pkg.sv
// Shared types and constants for the trilinear splat accumulator.
// No dependencies.
package tsa_pkg;

  localparam int LOC_W  = 24;
  localparam int INV_W  = 16;
  localparam int PROD_W = 41;
  localparam int BASE_W = 21;
  localparam int FRAC_W = 8;
  localparam int VAL_W  = 16;
  localparam int ACC_W  = 32;
  localparam int SIZE_W = 6;
  localparam int EXT_W  = 11;
  localparam int VOX_W  = 5;
  localparam int CNT_W  = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic CMD_SPLAT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_RES_X = 3'd0,
    REG_INV_RES_Y = 3'd1,
    REG_INV_RES_Z = 3'd2,
    REG_SIZE_X    = 3'd3,
    REG_SIZE_Y    = 3'd4,
    REG_SIZE_Z    = 3'd5
  } cfg_reg_t;

  // One classified item as it travels from front to back.
  typedef struct packed {
    logic                     cmd;
    logic                     rank_ok;
    logic                     rank;
    logic signed [BASE_W-1:0] bx;
    logic signed [BASE_W-1:0] by;
    logic signed [BASE_W-1:0] bz;
    logic [FRAC_W-1:0]        fx;
    logic [FRAC_W-1:0]        fy;
    logic [FRAC_W-1:0]        fz;
    logic                     neg;
    logic [VAL_W-1:0]         mag;
  } entry_t;

  // One result from the back end.
  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] read_value;
    logic [CNT_W-1:0]        corners;
    logic                    saturated;
  } result_t;

endpackage

// File: rtl/tsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tsa_queue.sv
// Two-entry queue of classified items between front and back.
// Depends on tsa_pkg.
module tsa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tsa_pkg::entry_t push_data,
  input  logic            pop,
  output tsa_pkg::entry_t head,
  output logic            empty,
  output logic            full
);

  tsa_pkg::entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign empty   = (count == 2'd0);
  assign full    = (count == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/tsa_front.sv
// Front end: register an accepted item, scale its position, classify it.
// Depends on tsa_pkg.
module tsa_front #(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 32,
  parameter int RANKS = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  logic                                  cmd,
  input  logic signed [tsa_pkg::LOC_W-1:0]      loc_x,
  input  logic signed [tsa_pkg::LOC_W-1:0]      loc_y,
  input  logic signed [tsa_pkg::LOC_W-1:0]      loc_z,
  input  logic signed [tsa_pkg::VAL_W-1:0]      sample_value,
  input  logic                                  volume_rank,
  input  logic [tsa_pkg::VOX_W-1:0]             voxel_x,
  input  logic [tsa_pkg::VOX_W-1:0]             voxel_y,
  input  logic [tsa_pkg::VOX_W-1:0]             voxel_z,
  input  logic [tsa_pkg::INV_W-1:0]             inv_res_x,
  input  logic [tsa_pkg::INV_W-1:0]             inv_res_y,
  input  logic [tsa_pkg::INV_W-1:0]             inv_res_z,
  input  logic                                  q_full,
  output logic                                  push,
  output tsa_pkg::entry_t                       push_data,
  output logic                                  stall
);

  localparam int PW = tsa_pkg::PROD_W;
  localparam int IW = tsa_pkg::INV_W;

  logic                               s1_valid;
  logic                               s1_cmd;
  logic                               s1_rank;
  logic signed [PW-1:0]               px;
  logic signed [PW-1:0]               py;
  logic signed [PW-1:0]               pz;
  logic signed [tsa_pkg::VAL_W-1:0]   s1_val;
  logic [tsa_pkg::VOX_W-1:0]          s1_vx;
  logic [tsa_pkg::VOX_W-1:0]          s1_vy;
  logic [tsa_pkg::VOX_W-1:0]          s1_vz;
  logic                               addr_ok;
  logic                               rank_in;

  assign push  = s1_valid && !q_full;
  assign stall = s1_valid && q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  // Scale Q16.8 by Q4.12 into Q20.20 voxel units.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd  <= cmd;
      s1_rank <= volume_rank;
      px      <= PW'(loc_x) * $signed({(PW-IW)'(0), inv_res_x});
      py      <= PW'(loc_y) * $signed({(PW-IW)'(0), inv_res_y});
      pz      <= PW'(loc_z) * $signed({(PW-IW)'(0), inv_res_z});
      s1_val  <= sample_value;
      s1_vx   <= voxel_x;
      s1_vy   <= voxel_y;
      s1_vz   <= voxel_z;
    end
  end

  assign rank_in = (32'(s1_rank) < 32'(RANKS));
  assign addr_ok = (32'(s1_vx) < 32'(MAX_X)) && (32'(s1_vy) < 32'(MAX_Y)) &&
                   (32'(s1_vz) < 32'(MAX_Z));

  always_comb begin
    push_data.cmd     = s1_cmd;
    push_data.rank    = s1_rank;
    push_data.neg     = s1_val[tsa_pkg::VAL_W-1];
    push_data.mag     = s1_val[tsa_pkg::VAL_W-1] ? (~s1_val + 16'd1) : s1_val;
    if (s1_cmd == tsa_pkg::CMD_READ) begin
      push_data.rank_ok = rank_in && addr_ok;
      push_data.bx = tsa_pkg::BASE_W'(s1_vx);
      push_data.by = tsa_pkg::BASE_W'(s1_vy);
      push_data.bz = tsa_pkg::BASE_W'(s1_vz);
      push_data.fx = '0;
      push_data.fy = '0;
      push_data.fz = '0;
    end else begin
      push_data.rank_ok = rank_in;
      push_data.bx = px[PW-1:20];
      push_data.by = py[PW-1:20];
      push_data.bz = pz[PW-1:20];
      push_data.fx = px[19:12];
      push_data.fy = py[19:12];
      push_data.fz = pz[19:12];
    end
  end

endmodule

// File: rtl/tsa_back.sv
// Back end: clear the voxel store; serve reads, walk corners and accumulate.
// Depends on tsa_pkg and tsa_ram.
module tsa_back #(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 32,
  parameter int RANKS = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tsa_pkg::entry_t               head,
  input  logic                          q_empty,
  input  logic [tsa_pkg::SIZE_W-1:0]    size_x,
  input  logic [tsa_pkg::SIZE_W-1:0]    size_y,
  input  logic [tsa_pkg::SIZE_W-1:0]    size_z,
  output logic                          pop,
  output logic                          clearing,
  output tsa_pkg::result_t              result
);

  localparam int DEPTH = RANKS * MAX_Z * MAX_Y * MAX_X;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = tsa_pkg::BASE_W;
  localparam int EW    = tsa_pkg::EXT_W;
  localparam int ACC   = tsa_pkg::ACC_W;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ADDR  = 6'b000100,
    S_WAIT  = 6'b001000,
    S_MUL   = 6'b010000,
    S_ADD   = 6'b100000
  } state_t;

  state_t                state;
  tsa_pkg::entry_t       cur;
  logic [2:0]            corner;
  logic [AW-1:0]         clr_cnt;
  logic [AW-1:0]         addr_q;
  logic [8:0]            wc_q;
  logic [17:0]           wxy_q;
  logic [24:0]           w_q;
  logic [16:0]           part_q;
  logic [tsa_pkg::CNT_W-1:0] cnt;
  logic                  sat;

  logic                  dx, dy, dz;
  logic signed [BW-1:0]  cx, cy, cz;
  logic [EW-1:0]         sx, sy, sz;
  logic                  in_vol;
  logic [AW-1:0]         addr;
  logic [8:0]            wa, wb, wc;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ACC-1:0]        ram_wdata;
  logic [ACC-1:0]        rdata;
  logic signed [ACC:0]   contrib;
  logic signed [ACC:0]   sum;
  logic [ACC-1:0]        sum_sat;
  logic                  clip;

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && !q_empty;

  assign dx = corner[0];
  assign dy = corner[1];
  assign dz = corner[2];
  assign cx = cur.bx + BW'(dx);
  assign cy = cur.by + BW'(dy);
  assign cz = cur.bz + BW'(dz);

  assign sx = (EW'(size_x) > EW'(MAX_X)) ? EW'(MAX_X) : EW'(size_x);
  assign sy = (EW'(size_y) > EW'(MAX_Y)) ? EW'(MAX_Y) : EW'(size_y);
  assign sz = (EW'(size_z) > EW'(MAX_Z)) ? EW'(MAX_Z) : EW'(size_z);

  assign in_vol = cur.rank_ok &&
                  !cx[BW-1] && ($unsigned(cx) < BW'(sx)) &&
                  !cy[BW-1] && ($unsigned(cy) < BW'(sy)) &&
                  !cz[BW-1] && ($unsigned(cz) < BW'(sz));

  assign addr = ((AW'(cur.rank) * AW'(MAX_Z) + AW'($unsigned(cz))) * AW'(MAX_Y)
                 + AW'($unsigned(cy))) * AW'(MAX_X) + AW'($unsigned(cx));

  assign wa = dx ? {1'b0, cur.fx} : (9'd256 - {1'b0, cur.fx});
  assign wb = dy ? {1'b0, cur.fy} : (9'd256 - {1'b0, cur.fy});
  assign wc = dz ? {1'b0, cur.fz} : (9'd256 - {1'b0, cur.fz});

  assign contrib = cur.neg ? -$signed({16'd0, part_q}) : $signed({16'd0, part_q});
  assign sum     = $signed({rdata[ACC-1], rdata}) + contrib;
  always_comb begin
    clip    = 1'b0;
    sum_sat = sum[ACC-1:0];
    if (sum[ACC] != sum[ACC-1]) begin
      clip    = 1'b1;
      sum_sat = sum[ACC] ? {1'b1, {(ACC-1){1'b0}}} : {1'b0, {(ACC-1){1'b1}}};
    end
  end

  assign ram_we    = clearing || (state == S_ADD);
  assign ram_waddr = clearing ? clr_cnt : addr_q;
  assign ram_wdata = clearing ? '0 : sum_sat;

  tsa_ram #(.WIDTH(ACC), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state == S_ADDR),
    .raddr (addr),
    .rdata (rdata)
  );

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == S_ADDR) begin
      addr_q <= addr;
      wxy_q  <= 18'(wa * wb);
      wc_q   <= wc;
    end
    if (state == S_WAIT) begin
      w_q <= 25'(wxy_q * wc_q);
    end
    if (state == S_MUL) begin
      part_q <= 17'((41'(w_q) * 41'(cur.mag)) >> 24);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      corner      <= '0;
      cnt         <= '0;
      sat         <= 1'b0;
      result.done <= 1'b0;
    end else begin
      result.done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            corner <= '0;
            cnt    <= '0;
            sat    <= 1'b0;
            state  <= S_ADDR;
          end
        end
        S_ADDR: begin
          if (cur.cmd == tsa_pkg::CMD_READ || in_vol) begin
            state <= S_WAIT;
          end else if (corner == 3'd7) begin
            result.done       <= 1'b1;
            result.read_value <= '0;
            result.corners    <= cnt;
            result.saturated  <= sat;
            state             <= S_IDLE;
          end else begin
            corner <= corner + 3'd1;
          end
        end
        S_WAIT: begin
          if (cur.cmd == tsa_pkg::CMD_READ) begin
            result.done       <= 1'b1;
            result.read_value <= cur.rank_ok ? rdata : '0;
            result.corners    <= '0;
            result.saturated  <= 1'b0;
            state             <= S_IDLE;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          if (corner == 3'd7) begin
            result.done       <= 1'b1;
            result.read_value <= '0;
            result.corners    <= cnt + 4'd1;
            result.saturated  <= sat || clip;
            state             <= S_IDLE;
          end else begin
            cnt    <= cnt + 4'd1;
            sat    <= sat || clip;
            corner <= corner + 3'd1;
            state  <= S_ADDR;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/trilinear_splat_accumulator_unit.sv
// Top level of the trilinear splat accumulator: config registers, front end,
// queue, back end. Depends on tsa_pkg, tsa_front, tsa_queue, tsa_back, macros.
//
//   channel  | handshake            | beat contents
//   ---------+----------------------+-------------------------------------------
//   item in  | start high, busy low | cmd, loc_x/y/z, sample_value, volume_rank,
//            |                      | voxel_x/y/z
//   result   | done, one cycle      | read_value, corners_written, saturated
//   config   | cfg_we               | cfg_index, cfg_data
//
// With the back idle, done of a read rises after its accepting edge has passed
// the front register, the queue, the address state and the read state. A splat
// spends only the address state on a corner outside the volume and goes through
// read, weight, scale and add for each corner inside, one corner at a time.
// After reset the store is cleared one word a cycle, RANKS*MAX_Z*MAX_Y*MAX_X words
// (65536 at default sizes), with busy held high.
// A two-entry queue lets the front take new items while the back works; busy
// rises when the front holds a beat that the full queue cannot take.
// The receiver cannot stall: each result shows for exactly one cycle.
`include "trilinear_splat_accumulator_unit_macros.svh"

module trilinear_splat_accumulator_unit #(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 32,
  parameter int RANKS = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 cmd,
  input  logic signed [tsa_pkg::LOC_W-1:0]     loc_x,
  input  logic signed [tsa_pkg::LOC_W-1:0]     loc_y,
  input  logic signed [tsa_pkg::LOC_W-1:0]     loc_z,
  input  logic signed [tsa_pkg::VAL_W-1:0]     sample_value,
  input  logic                                 volume_rank,
  input  logic [tsa_pkg::VOX_W-1:0]            voxel_x,
  input  logic [tsa_pkg::VOX_W-1:0]            voxel_y,
  input  logic [tsa_pkg::VOX_W-1:0]            voxel_z,
  input  logic                                 cfg_we,
  input  logic [tsa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tsa_pkg::INV_W-1:0]            cfg_data,
  output logic                                 done,
  output logic signed [tsa_pkg::ACC_W-1:0]     read_value,
  output logic [tsa_pkg::CNT_W-1:0]            corners_written,
  output logic                                 saturated
);

  logic [tsa_pkg::INV_W-1:0]  inv_res_x;
  logic [tsa_pkg::INV_W-1:0]  inv_res_y;
  logic [tsa_pkg::INV_W-1:0]  inv_res_z;
  logic [tsa_pkg::SIZE_W-1:0] size_x;
  logic [tsa_pkg::SIZE_W-1:0] size_y;
  logic [tsa_pkg::SIZE_W-1:0] size_z;

  logic             accept;
  logic             push;
  tsa_pkg::entry_t  push_data;
  logic             stall;
  logic             pop;
  tsa_pkg::entry_t  head;
  logic             q_empty;
  logic             q_full;
  logic             clearing;
  tsa_pkg::result_t result;

  // Hold off new beats while clearing or while the front cannot drain.
  assign busy   = clearing || stall;
  assign accept = start && !busy;

  // Configuration: write on enable, ignore indexes past the register list.
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_res_x <= 16'd4096;
      inv_res_y <= 16'd4096;
      inv_res_z <= 16'd4096;
      size_x    <= 6'd32;
      size_y    <= 6'd32;
      size_z    <= 6'd32;
    end else if (cfg_we) begin
      case (tsa_pkg::cfg_reg_t'(cfg_index))
        tsa_pkg::REG_INV_RES_X: inv_res_x <= cfg_data;
        tsa_pkg::REG_INV_RES_Y: inv_res_y <= cfg_data;
        tsa_pkg::REG_INV_RES_Z: inv_res_z <= cfg_data;
        tsa_pkg::REG_SIZE_X:    size_x    <= cfg_data[tsa_pkg::SIZE_W-1:0];
        tsa_pkg::REG_SIZE_Y:    size_y    <= cfg_data[tsa_pkg::SIZE_W-1:0];
        tsa_pkg::REG_SIZE_Z:    size_z    <= cfg_data[tsa_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  tsa_front #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .RANKS(RANKS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cmd          (cmd),
    .loc_x        (loc_x),
    .loc_y        (loc_y),
    .loc_z        (loc_z),
    .sample_value (sample_value),
    .volume_rank  (volume_rank),
    .voxel_x      (voxel_x),
    .voxel_y      (voxel_y),
    .voxel_z      (voxel_z),
    .inv_res_x    (inv_res_x),
    .inv_res_y    (inv_res_y),
    .inv_res_z    (inv_res_z),
    .q_full       (q_full),
    .push         (push),
    .push_data    (push_data),
    .stall        (stall)
  );

  tsa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  tsa_back #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .RANKS(RANKS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .size_x   (size_x),
    .size_y   (size_y),
    .size_z   (size_z),
    .pop      (pop),
    .clearing (clearing),
    .result   (result)
  );

  assign done            = result.done;
  assign read_value      = result.read_value;
  assign corners_written = result.corners;
  assign saturated       = result.saturated;

  `TSA_ASSERT_NEXT(a_done_single, done, !done, "result strobe lasted two cycles")
  `TSA_ASSERT_SAME(a_corner_max, done, corners_written <= 4'd8, "corner count above eight")
  `TSA_ASSERT_SAME(a_clear_busy, clearing, busy, "item accepted during clearing pass")
  `TSA_ASSERT_SAME(a_read_clean, done && read_value != 0,
                   corners_written == 4'd0 && !saturated, "read result carries splat status")

endmodule
